// ----- hw/rtl/clrb_pkg.sv -----
// Package for the console line ring buffer: item structs, command and
// event codes, character constants and ring geometry.
// No dependencies.
package clrb_pkg;

  // Ring geometry; the result field widths follow from it
  localparam int unsigned LINE_SIZE   = 256;
  localparam int unsigned PTR_W       = $clog2(LINE_SIZE);
  localparam int unsigned CNT_W       = PTR_W + 1;
  localparam int unsigned ESC_LEN_DEF = 16;
  localparam int unsigned LC_W        = 9;
  localparam logic [LC_W-1:0] LINES_MAX = '1;

  // Command codes
  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_DONE = 2'd2;

  // Echo codes
  localparam logic [1:0] ECHO_NONE  = 2'd0;
  localparam logic [1:0] ECHO_CHAR  = 2'd1;
  localparam logic [1:0] ECHO_ERASE = 2'd2;

  // Key event codes
  localparam logic [1:0] KEY_NONE  = 2'd0;
  localparam logic [1:0] KEY_BREAK = 2'd1;
  localparam logic [1:0] KEY_WHO   = 2'd2;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_R     = 8'h52;

  // Effect of an item on the line counter, applied when its result leaves
  typedef enum logic [1:0] {
    LOP_NONE,
    LOP_CR_IN,
    LOP_READ,
    LOP_CLEAR
  } lop_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] char_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       read_char;
    logic [1:0]       echo_code;
    logic             line_event;
    logic [1:0]       key_event;
    logic [CNT_W-1:0] chars_pending;
    logic             line_waiting;
  } out_item_t;

endpackage

// ----- hw/rtl/console_line_ring_buffer_unit.sv -----
// Console line ring buffer: top level with the byte store, pointer logic,
// escape decoder and output register.
// Depends on clrb_pkg.
//
// Usage: each input item carries a command (push byte, read byte, complete
// line) and a byte. Each accepted item gives exactly one result item with
// the read byte, echo request, line and key events, pending count and the
// line-waiting flag.
// Latency: the result of an item is shown on the output the cycle after it
// is accepted. Throughput: one item per cycle while the output is not stalled;
// the byte store does one write or one read per item, read data registered.
// Pointer and count updates happen at acceptance; the line counter and the
// line-waiting flag depend on the byte read, so they are updated when the
// result item is taken from the output register.
// Reset: the write pointer, counts and escape state clear at once and the read
// pointer is set one past the end; the byte store is not cleared and needs no
// clearing pass. Items are taken from the first cycle after reset.
// Stall: while the receiver stalls a waiting result, in_stall_o is raised
// and the result holds; when the result is taken a new item is accepted in
// the same cycle.
module console_line_ring_buffer_unit
  import clrb_pkg::*;
#(
  parameter int unsigned ESC_LEN = ESC_LEN_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned ESC_W = $clog2(ESC_LEN + 1);

  typedef struct packed {
    lop_e             lop;
    logic             is_read;
    logic             read_hit;
    logic [1:0]       echo_code;
    logic             line_event;
    logic [1:0]       key_event;
    logic [CNT_W-1:0] pending;
  } s1_t;

  logic [7:0] mem [LINE_SIZE];
  logic [7:0] rdata_q;

  logic [PTR_W-1:0] wp_q, wp_d;
  logic [CNT_W-1:0] rp_q, rp_d;
  logic [CNT_W-1:0] pend_q, pend_d;
  logic [LC_W-1:0]  lc_q, lc_d;
  logic             ready_q, ready_d;
  logic [7:0]       prev_q, prev_d;
  logic             esc_q, esc_d;
  logic [ESC_W-1:0] esc_cnt_q, esc_cnt_d;
  logic             out_valid_q;
  s1_t              s1_q, s1_d;

  logic             accept, out_fire, mem_we;
  logic [PTR_W-1:0] wp_inc, wp_dec, rd_nxt;
  logic [7:0]       c;

  assign out_fire   = out_valid_q && !out_stall_i;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign c          = in_item_i.char_in;

  assign wp_inc = (wp_q == PTR_W'(LINE_SIZE - 1)) ? '0 : wp_q + PTR_W'(1);
  assign wp_dec = (wp_q == '0) ? PTR_W'(LINE_SIZE - 1) : wp_q - PTR_W'(1);
  // read_pos may sit one past the end; both that and the last entry wrap to 0
  assign rd_nxt = (rp_q >= CNT_W'(LINE_SIZE - 1)) ? '0 : rp_q[PTR_W-1:0] + PTR_W'(1);

  // Stage 0: pointer, count and escape updates for the accepted item
  always_comb begin
    wp_d      = wp_q;
    rp_d      = rp_q;
    pend_d    = pend_q;
    prev_d    = prev_q;
    esc_d     = esc_q;
    esc_cnt_d = esc_cnt_q;
    mem_we    = 1'b0;
    s1_d      = '{lop: LOP_NONE, is_read: 1'b0, read_hit: 1'b0, echo_code: ECHO_NONE,
                  line_event: 1'b0, key_event: KEY_NONE, pending: '0};
    case (in_item_i.command)
      CMD_PUSH: begin
        if (c == CH_LF) begin
          // drop line feeds
        end else if (c == CH_ESC) begin
          esc_d     = 1'b1;
          esc_cnt_d = '0;
        end else if (esc_q) begin
          if (esc_cnt_q >= ESC_W'(ESC_LEN)) begin
            esc_d = 1'b0;
          end else begin
            esc_cnt_d = esc_cnt_q + ESC_W'(1);
            if (c >= CH_A && c <= CH_D) begin
              // cursor keys: stay in escape mode
            end else if (c == CH_F) begin
              s1_d.key_event = KEY_BREAK;
              esc_d          = 1'b0;
            end else if (c == CH_H) begin
              s1_d.key_event = KEY_WHO;
              esc_d          = 1'b0;
            end else if (c == CH_TILDE || c == CH_R || c < CH_SPACE || c > CH_TILDE) begin
              esc_d = 1'b0;
            end
          end
        end else begin
          if (prev_q == CH_CR && c == CH_NUL) begin
            // swallow a NUL after CR
          end else if (c == CH_BS || c == CH_DEL) begin
            if (pend_q != '0) begin
              pend_d         = pend_q - CNT_W'(1);
              wp_d           = wp_dec;
              s1_d.echo_code = ECHO_ERASE;
            end
          end else begin
            s1_d.echo_code = ECHO_CHAR;
            prev_d         = c;
            mem_we         = 1'b1;
            if ({1'b0, wp_inc} != rp_q) begin
              wp_d = wp_inc;
              if (pend_q < CNT_W'(LINE_SIZE)) begin
                pend_d = pend_q + CNT_W'(1);
              end
            end else begin
              // full ring: keep the byte slot, do not advance
              s1_d.line_event = 1'b1;
            end
          end
          if (c == CH_CR) begin
            s1_d.lop        = LOP_CR_IN;
            s1_d.line_event = 1'b1;
          end
        end
      end
      CMD_READ: begin
        s1_d.is_read = 1'b1;
        if (pend_q != '0 && rd_nxt != wp_q) begin
          pend_d        = pend_q - CNT_W'(1);
          rp_d          = {1'b0, rd_nxt};
          s1_d.read_hit = 1'b1;
          s1_d.lop      = LOP_READ;
        end
      end
      CMD_DONE: begin
        pend_d   = '0;
        rp_d     = {1'b0, wp_dec};
        s1_d.lop = LOP_CLEAR;
      end
      default: begin
      end
    endcase
    s1_d.pending = pend_d;
  end

  // Stage 1: line counter update, depends on the byte read
  always_comb begin
    lc_d    = lc_q;
    ready_d = ready_q;
    case (s1_q.lop)
      LOP_CR_IN: begin
        ready_d = 1'b1;
        if (lc_q != LINES_MAX) begin
          lc_d = lc_q + LC_W'(1);
        end
      end
      LOP_READ: begin
        if (rdata_q == CH_CR) begin
          if (lc_q != '0) begin
            lc_d    = lc_q - LC_W'(1);
            ready_d = (lc_q != LC_W'(1));
          end else begin
            ready_d = 1'b0;
          end
        end
      end
      LOP_CLEAR: ready_d = 1'b0;
      default: begin
      end
    endcase
  end

  always_comb begin
    out_item_o.read_char     = s1_q.read_hit ? rdata_q : (s1_q.is_read ? CH_CR : CH_NUL);
    out_item_o.echo_code     = s1_q.echo_code;
    out_item_o.line_event    = s1_q.line_event;
    out_item_o.key_event     = s1_q.key_event;
    out_item_o.chars_pending = s1_q.pending;
    out_item_o.line_waiting  = ready_d;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i) begin
    if (accept && mem_we) begin
      mem[wp_q] <= c;
    end
    if (accept && s1_d.is_read) begin
      rdata_q <= mem[rd_nxt];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      rp_q        <= CNT_W'(LINE_SIZE);
      pend_q      <= '0;
      prev_q      <= '0;
      esc_q       <= 1'b0;
      esc_cnt_q   <= '0;
      lc_q        <= '0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        wp_q      <= wp_d;
        rp_q      <= rp_d;
        pend_q    <= pend_d;
        prev_q    <= prev_d;
        esc_q     <= esc_d;
        esc_cnt_q <= esc_cnt_d;
      end
      if (out_fire) begin
        lc_q    <= lc_d;
        ready_q <= ready_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= CNT_W'(LINE_SIZE))
    else $error("pending count beyond ring size");

  a_esc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_cnt_q <= ESC_W'(ESC_LEN))
    else $error("escape count beyond limit");

  a_read_hit_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s1_d.read_hit |=> pend_q == $past(pend_q) - CNT_W'(1))
    else $error("read hit did not take one pending byte");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled with empty output register");

endmodule
